/* design/gaps_pkg.sv */
// ----------------------------------------------------------------------------
// gaps_pkg
// shared types, constants and helpers of the grid path search unit
// ----------------------------------------------------------------------------
package gaps_pkg;

  localparam int COORD_W       = 3;
  localparam int CELL_W        = 2 * COORD_W;
  localparam int NUM_CELLS     = 1 << CELL_W;
  localparam int COST_W        = 10;
  localparam int GSUM_W        = COST_W + 1;
  localparam int H_W           = 8;
  localparam int CNT_W         = CELL_W + 1;
  localparam int DEF_GRID_ROWS = 8;
  localparam int DEF_GRID_COLS = 8;
  localparam int PADDR_W       = 4;
  localparam int PDATA_W       = 64;
  localparam int STEP_STRAIGHT = 10;
  localparam int STEP_DIAG     = 14;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [CELL_W-1:0]    cell_t;
  typedef logic [NUM_CELLS-1:0] mark_t;

  // register index, taken from the 8-byte aligned address
  typedef enum logic [0:0] {
    REG_DIAG_ENABLE,
    REG_WALL_MAP
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SEL,
    ST_SCAN_Q,
    ST_SCAN_C,
    ST_SCAN_CMP,
    ST_POP_CHK,
    ST_SHIFT_WR,
    ST_NB,
    ST_NB_UPD,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT,
    ST_EMIT_NEXT,
    ST_NONE
  } state_t;

  typedef enum logic [1:0] {
    NB_SKIP,
    NB_GOAL,
    NB_NEW,
    NB_OPEN
  } nb_kind_t;

  typedef struct packed {
    logic load_in;
    logic init;
    logic sel_start;
    logic scan_rd_q;
    logic scan_rd_c;
    logic scan_cmp;
    logic shift_rd;
    logic shift_wr;
    logic pop_done;
    logic nb_eval;
    logic nb_upd;
    logic emit_load;
    logic emit_rd;
    logic emit_next;
    logic none_load;
  } cmd_t;

  typedef struct packed {
    logic     same_cell;
    logic     open_empty;
    logic     scan_last;
    logic     shift_more;
    nb_kind_t nb_kind;
    logic     nb_last;
    logic     out_fire;
    logic     out_last;
  } stat_t;

  function automatic coord_t clamp_coord(coord_t v, int lim);
    coord_t r;
    if (int'(v) >= lim) begin
      r = COORD_W'(lim - 1);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [H_W-1:0] heur(cell_t n, cell_t g);
    logic [COORD_W:0] dr;
    logic [COORD_W:0] dc;
    logic [H_W-1:0]   d;
    dr = (n[CELL_W-1:COORD_W] > g[CELL_W-1:COORD_W]) ?
         {1'b0, n[CELL_W-1:COORD_W]} - {1'b0, g[CELL_W-1:COORD_W]} :
         {1'b0, g[CELL_W-1:COORD_W]} - {1'b0, n[CELL_W-1:COORD_W]};
    dc = (n[COORD_W-1:0] > g[COORD_W-1:0]) ?
         {1'b0, n[COORD_W-1:0]} - {1'b0, g[COORD_W-1:0]} :
         {1'b0, g[COORD_W-1:0]} - {1'b0, n[COORD_W-1:0]};
    d = H_W'(dr) + H_W'(dc);
    return (d << 3) + (d << 1);
  endfunction

endpackage

/* design/grid_astar_path_search_unit.sv */
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit
// A* path search between two cells of a small grid with a wall bitmap
// ----------------------------------------------------------------------------
// One input transfer carries a start and a goal cell; the unit runs A* over
// the grid (walls in wall_map, diagonals when diag_enable is set) and returns
// the path one cell per output transfer, goal first, last set on the start
// cell. No path, or start equal to goal, gives one transfer with found=0 and
// last=1. One search at a time: in_ready is high only while the unit is idle.
// Search time goes per expansion to scanning every open entry, shifting the
// entries behind the removed one and evaluating the neighbours, and per path
// cell to the parent read and the output handshake; the open-list scan through
// the queue and cost memories dominates. Registers sit on the apb port at
// byte offsets 0 (diag_enable) and 8 (wall_map, 64 bits); write them only
// while idle.
module grid_astar_path_search_unit
  import gaps_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  coord_t             in_start_row,
  input  coord_t             in_start_col,
  input  coord_t             in_goal_row,
  input  coord_t             in_goal_col,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output coord_t             out_cell_row,
  output coord_t             out_cell_col,
  output logic               out_last,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic                 diag_en_r;
  logic [PDATA_W-1:0]   wall_map_r;
  reg_idx_t             reg_idx;
  cmd_t                 cmd;
  stat_t                stat;

  // registers are 8 bytes apart, so the top address bit picks one
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_en_r  <= 1'b0;
      wall_map_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_DIAG_ENABLE: diag_en_r  <= pwdata[0];
        REG_WALL_MAP:    wall_map_r <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_DIAG_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, diag_en_r};
      REG_WALL_MAP:    prdata = wall_map_r;
      default:         prdata = '0;
    endcase
  end

  // sequencer
  gaps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // queue, cost and parent storage plus output stage
  gaps_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .diag_en      (diag_en_r),
    .wall_map     (wall_map_r[NUM_CELLS-1:0]),
    .in_start_row (in_start_row),
    .in_start_col (in_start_col),
    .in_goal_row  (in_goal_row),
    .in_goal_col  (in_goal_col),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_cell_row (out_cell_row),
    .out_cell_col (out_cell_col),
    .out_last     (out_last)
  );

`ifndef SYNTHESIS
  // a new search is never taken while a result waits
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  // after a non-final path cell the search stays busy
  a_path_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> !in_ready)
    else $error("unit went idle in the middle of a path");

  // a no-path result always closes the search
  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_last)
    else $error("no-path result without last");
`endif

endmodule

/* design/gaps_ctrl.sv */
// ----------------------------------------------------------------------------
// gaps_ctrl
// search sequencer: scan, pop, neighbour expansion and path emission
// ----------------------------------------------------------------------------
module gaps_ctrl
  import gaps_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_INIT;
      end
      ST_INIT:      state_nxt = stat.same_cell ? ST_NONE : ST_SEL;
      ST_SEL:       state_nxt = stat.open_empty ? ST_NONE : ST_SCAN_Q;
      ST_SCAN_Q:    state_nxt = ST_SCAN_C;
      ST_SCAN_C:    state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP:  state_nxt = stat.scan_last ? ST_POP_CHK : ST_SCAN_Q;
      ST_POP_CHK:   state_nxt = stat.shift_more ? ST_SHIFT_WR : ST_NB;
      ST_SHIFT_WR:  state_nxt = ST_POP_CHK;
      ST_NB: begin
        unique case (stat.nb_kind)
          NB_GOAL: state_nxt = ST_EMIT_LOAD;
          NB_OPEN: state_nxt = ST_NB_UPD;
          default: state_nxt = stat.nb_last ? ST_SEL : ST_NB;
        endcase
      end
      ST_NB_UPD:    state_nxt = stat.nb_last ? ST_SEL : ST_NB;
      ST_EMIT_LOAD: state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (stat.out_fire) state_nxt = stat.out_last ? ST_IDLE : ST_EMIT_NEXT;
      end
      ST_EMIT_NEXT: state_nxt = ST_EMIT_LOAD;
      ST_NONE:      state_nxt = ST_EMIT_WAIT;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_INIT:     cmd.init      = 1'b1;
      ST_SEL:      cmd.sel_start = !stat.open_empty;
      ST_SCAN_Q:   cmd.scan_rd_q = 1'b1;
      ST_SCAN_C:   cmd.scan_rd_c = 1'b1;
      ST_SCAN_CMP: cmd.scan_cmp  = 1'b1;
      ST_POP_CHK: begin
        cmd.shift_rd = stat.shift_more;
        cmd.pop_done = !stat.shift_more;
      end
      ST_SHIFT_WR:  cmd.shift_wr  = 1'b1;
      ST_NB:        cmd.nb_eval   = 1'b1;
      ST_NB_UPD:    cmd.nb_upd    = 1'b1;
      ST_EMIT_LOAD: cmd.emit_load = 1'b1;
      ST_EMIT_WAIT: cmd.emit_rd   = stat.out_fire && !stat.out_last;
      ST_EMIT_NEXT: cmd.emit_next = 1'b1;
      ST_NONE:      cmd.none_load = 1'b1;
      default: ;
    endcase
  end

endmodule

/* design/gaps_dp.sv */
// ----------------------------------------------------------------------------
// gaps_dp
// search datapath: open queue, cost and parent memories, marks, output stage
// ----------------------------------------------------------------------------
module gaps_dp
  import gaps_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic                    diag_en,
  input  logic [NUM_CELLS-1:0]    wall_map,
  input  coord_t                  in_start_row,
  input  coord_t                  in_start_col,
  input  coord_t                  in_goal_row,
  input  coord_t                  in_goal_col,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_found,
  output coord_t                  out_cell_row,
  output coord_t                  out_cell_col,
  output logic                    out_last
);

  // memories
  cell_t             queue_mem [NUM_CELLS];
  logic [COST_W-1:0] cost_mem  [NUM_CELLS];
  cell_t             parent_mem[NUM_CELLS];
  cell_t             queue_q_r;
  logic [COST_W-1:0] cost_q_r;
  cell_t             parent_q_r;

  cell_t             s_r;
  cell_t             g_r;
  logic [CELL_W-1:0] k_r;
  logic [CNT_W-1:0]  count_r;
  mark_t             open_mark_r;
  mark_t             closed_mark_r;
  logic              first_r;
  logic [CELL_W-1:0] best_k_r;
  cell_t             best_cell_r;
  logic [COST_W-1:0] best_g_r;
  logic [GSUM_W-1:0] best_f_r;
  logic [H_W-1:0]    best_h_r;
  logic [1:0]        di_r;
  logic [1:0]        dj_r;
  cell_t             node_r;
  logic              out_valid_r;
  logic              out_found_r;
  cell_t             out_cell_r;
  logic              out_last_r;

  function automatic logic is_wall(cell_t c, cell_t s, cell_t g,
                                   logic [NUM_CELLS-1:0] wm);
    logic [CELL_W-1:0] idx;
    idx = CELL_W'(int'(c[CELL_W-1:COORD_W]) * GRID_COLS + int'(c[COORD_W-1:0]));
    return (c != s) && (c != g) && wm[idx];
  endfunction

  // scan compare
  logic [H_W-1:0]    cand_h;
  logic [GSUM_W-1:0] cand_f;
  logic              cand_better;
  logic [CNT_W-1:0]  k_inc;

  always_comb begin
    cand_h      = heur(queue_q_r, g_r);
    cand_f      = (queue_q_r == s_r) ? '0 : GSUM_W'(cost_q_r) + GSUM_W'(cand_h);
    cand_better = first_r || (cand_f < best_f_r) ||
                  ((cand_f == best_f_r) && (cand_h < best_h_r));
    k_inc       = CNT_W'(k_r) + CNT_W'(1);
  end

  // neighbour evaluation
  coord_t            cur_row;
  coord_t            cur_col;
  logic [COORD_W:0]  nr_sum;
  logic [COORD_W:0]  nc_sum;
  coord_t            nr;
  coord_t            nc;
  logic              in_grid;
  logic              center;
  logic              diag;
  cell_t             n_cell;
  nb_kind_t          nb_kind;
  logic [GSUM_W-1:0] newg;
  logic              nb_better;

  always_comb begin
    cur_row = best_cell_r[CELL_W-1:COORD_W];
    cur_col = best_cell_r[COORD_W-1:0];
    nr_sum  = {1'b0, cur_row} + (COORD_W+1)'(di_r);
    nc_sum  = {1'b0, cur_col} + (COORD_W+1)'(dj_r);
    nr      = COORD_W'(nr_sum - 1'b1);
    nc      = COORD_W'(nc_sum - 1'b1);
    in_grid = (nr_sum != '0) && (int'(nr_sum) <= GRID_ROWS) &&
              (nc_sum != '0) && (int'(nc_sum) <= GRID_COLS);
    center  = (di_r == 2'd1) && (dj_r == 2'd1);
    diag    = (di_r != 2'd1) && (dj_r != 2'd1);
    n_cell  = {nr, nc};
    newg    = GSUM_W'(best_g_r) + (diag ? GSUM_W'(STEP_DIAG) : GSUM_W'(STEP_STRAIGHT));
    nb_better = newg < GSUM_W'(cost_q_r);
    nb_kind = NB_SKIP;
    if (center || !in_grid) begin
      nb_kind = NB_SKIP;
    end else if (diag && (!diag_en ||
                 (is_wall({nr, cur_col}, s_r, g_r, wall_map) &&
                  is_wall({cur_row, nc}, s_r, g_r, wall_map)))) begin
      nb_kind = NB_SKIP;
    end else if (is_wall(n_cell, s_r, g_r, wall_map) || closed_mark_r[n_cell]) begin
      nb_kind = NB_SKIP;
    end else if (n_cell == g_r) begin
      nb_kind = NB_GOAL;
    end else if (!open_mark_r[n_cell]) begin
      nb_kind = (int'(count_r) < NUM_CELLS) ? NB_NEW : NB_SKIP;
    end else begin
      nb_kind = NB_OPEN;
    end
  end

  logic nb_new;
  logic nb_goal;
  logic nb_open;
  logic upd_wr;
  logic out_fire;

  assign nb_new   = cmd.nb_eval && (nb_kind == NB_NEW);
  assign nb_goal  = cmd.nb_eval && (nb_kind == NB_GOAL);
  assign nb_open  = cmd.nb_eval && (nb_kind == NB_OPEN);
  assign upd_wr   = cmd.nb_upd && nb_better;
  assign out_fire = out_valid_r && out_ready;

  // memory ports
  logic              q_we;
  cell_t             q_wa;
  cell_t             q_wd;
  logic              q_re;
  cell_t             q_ra;
  logic              c_we;
  cell_t             c_wa;
  logic [COST_W-1:0] c_wd;
  logic              c_re;
  cell_t             c_ra;
  logic              p_we;
  cell_t             p_wa;

  always_comb begin
    q_we = cmd.init || cmd.shift_wr || nb_new;
    q_wa = cmd.init ? '0 : (cmd.shift_wr ? k_r : count_r[CELL_W-1:0]);
    q_wd = cmd.init ? s_r : (cmd.shift_wr ? queue_q_r : n_cell);
    q_re = cmd.scan_rd_q || cmd.shift_rd;
    q_ra = cmd.shift_rd ? k_inc[CELL_W-1:0] : k_r;
    c_we = cmd.init || nb_new || upd_wr;
    c_wa = cmd.init ? s_r : n_cell;
    c_wd = cmd.init ? '0 : COST_W'(newg);
    c_re = cmd.scan_rd_c || nb_open;
    c_ra = cmd.scan_rd_c ? queue_q_r : n_cell;
    p_we = nb_new || nb_goal || upd_wr;
    p_wa = n_cell;
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_wa] <= q_wd;
    if (q_re) queue_q_r <= queue_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (c_we) cost_mem[c_wa] <= c_wd;
    if (c_re) cost_q_r <= cost_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) parent_mem[p_wa] <= best_cell_r;
    if (cmd.emit_rd) parent_q_r <= parent_mem[node_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      open_mark_r   <= '0;
      closed_mark_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.init) begin
        count_r       <= CNT_W'(1);
        open_mark_r   <= mark_t'(1) << s_r;
        closed_mark_r <= '0;
      end
      if (cmd.pop_done) begin
        count_r                    <= count_r - 1'b1;
        open_mark_r[best_cell_r]   <= 1'b0;
        closed_mark_r[best_cell_r] <= 1'b1;
      end
      if (nb_new) begin
        count_r             <= count_r + 1'b1;
        open_mark_r[n_cell] <= 1'b1;
      end
      if (cmd.emit_load || cmd.none_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      s_r <= {clamp_coord(in_start_row, GRID_ROWS), clamp_coord(in_start_col, GRID_COLS)};
      g_r <= {clamp_coord(in_goal_row, GRID_ROWS), clamp_coord(in_goal_col, GRID_COLS)};
    end
    if (cmd.sel_start) begin
      k_r     <= '0;
      first_r <= 1'b1;
    end
    if (cmd.scan_cmp) begin
      first_r <= 1'b0;
      if (cand_better) begin
        best_k_r    <= k_r;
        best_cell_r <= queue_q_r;
        best_g_r    <= cost_q_r;
        best_f_r    <= cand_f;
        best_h_r    <= cand_h;
      end
      // after the last entry, k points at the winner for the removal
      if (k_inc == count_r) begin
        k_r <= cand_better ? k_r : best_k_r;
      end else begin
        k_r <= k_inc[CELL_W-1:0];
      end
    end
    if (cmd.shift_wr) k_r <= k_inc[CELL_W-1:0];
    if (cmd.pop_done) begin
      di_r <= 2'd0;
      dj_r <= 2'd0;
    end
    if ((cmd.nb_eval && (nb_kind == NB_SKIP || nb_kind == NB_NEW)) || cmd.nb_upd) begin
      if (dj_r == 2'd2) begin
        dj_r <= 2'd0;
        di_r <= di_r + 2'd1;
      end else begin
        dj_r <= dj_r + 2'd1;
      end
    end
    if (nb_goal) node_r <= g_r;
    if (cmd.emit_next) node_r <= parent_q_r;
    if (cmd.emit_load) begin
      out_found_r <= 1'b1;
      out_cell_r  <= node_r;
      out_last_r  <= (node_r == s_r);
    end
    if (cmd.none_load) begin
      out_found_r <= 1'b0;
      out_cell_r  <= '0;
      out_last_r  <= 1'b1;
    end
  end

  always_comb begin
    stat.same_cell  = (s_r == g_r);
    stat.open_empty = (count_r == '0);
    stat.scan_last  = (k_inc == count_r);
    stat.shift_more = (k_inc < count_r);
    stat.nb_kind    = nb_kind;
    stat.nb_last    = (di_r == 2'd2) && (dj_r == 2'd2);
    stat.out_fire   = out_fire;
    stat.out_last   = out_last_r;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_cell_row = out_cell_r[CELL_W-1:COORD_W];
  assign out_cell_col = out_cell_r[COORD_W-1:0];
  assign out_last     = out_last_r;

endmodule
